// File: design/sliding_window_flood_lock_macros.svh
// Assertion helpers shared by the flood lock RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef SLIDING_WINDOW_FLOOD_LOCK_MACROS_SVH
`define SLIDING_WINDOW_FLOOD_LOCK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWFL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/swfl_pkg.sv
`default_nettype none

package swfl_pkg;

  // Fixed field widths.
  localparam int TIME_W    = 32;
  localparam int LIMIT_W   = 7;
  localparam int QUEUED_W  = 7;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Defaults and reset values.
  localparam int DEPTH_DEFAULT = 64;
  localparam logic [TIME_W-1:0]  WINDOW_RESET = 32'd1000;
  localparam logic [LIMIT_W-1:0] MAX_RESET    = 7'd64;

  // Item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_CHECK = 2'd0,
    MODE_LOCK  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 2'd0,
    REG_MAX    = 2'd1
  } reg_idx_t;

  // Program steps.
  typedef enum logic [1:0] {
    STEP_IDLE   = 2'd0,
    STEP_DISP   = 2'd1,
    STEP_EXPIRE = 2'd2
  } step_t;

  // Datapath operation selected by a control word.
  typedef enum logic [1:0] {
    OP_TAKE     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_EXPIRE   = 2'd2
  } op_t;

  // Jump conditions.
  typedef enum logic [1:0] {
    COND_NEVER     = 2'd0,
    COND_NOT_TAKEN = 2'd1,
    COND_DONE      = 2'd2,
    COND_POP       = 2'd3
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t jmp_cond;
    step_t jmp_target;
    step_t next_step;
  } ctl_word_t;

  // Status flags returned by the datapath to the sequencer.
  typedef struct packed {
    logic taken;
    logic done;
    logic pop;
  } seq_flags_t;

  // Control store.
  function automatic ctl_word_t ucode_rom(input step_t step);
    ctl_word_t w;
    w = '{op: OP_TAKE, jmp_cond: COND_NEVER, jmp_target: STEP_IDLE,
          next_step: STEP_IDLE};
    unique case (step)
      STEP_IDLE:   w = '{op: OP_TAKE, jmp_cond: COND_NOT_TAKEN,
                         jmp_target: STEP_IDLE, next_step: STEP_DISP};
      STEP_DISP:   w = '{op: OP_DISPATCH, jmp_cond: COND_DONE,
                         jmp_target: STEP_IDLE, next_step: STEP_EXPIRE};
      STEP_EXPIRE: w = '{op: OP_EXPIRE, jmp_cond: COND_POP,
                         jmp_target: STEP_EXPIRE, next_step: STEP_IDLE};
      default:     w = '{op: OP_TAKE, jmp_cond: COND_NEVER,
                         jmp_target: STEP_IDLE, next_step: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/swfl_ram.sv
`default_nettype none

module swfl_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/swfl_seq.sv
`default_nettype none

module swfl_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire swfl_pkg::seq_flags_t flags,
  output swfl_pkg::ctl_word_t       ctl,
  output swfl_pkg::step_t           step
);

  import swfl_pkg::*;

  step_t step_next;
  logic  jump;

  assign ctl = ucode_rom(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    unique case (ctl.jmp_cond)
      COND_NEVER:     jump = 1'b0;
      COND_NOT_TAKEN: jump = !flags.taken;
      COND_DONE:      jump = flags.done;
      COND_POP:       jump = flags.pop;
      default:        jump = 1'b0;
    endcase
    step_next = jump ? ctl.jmp_target : ctl.next_step;
  end

endmodule

`default_nettype wire

// File: design/sliding_window_flood_lock.sv
// Sliding-window flood lock. Each input transaction carries a mode and the
// current time in milliseconds; each one yields exactly one output
// transaction with accepted, locked, queued and total_accepted.
// Both data channels use valid/stall: a transaction moves on a rising edge
// where valid is high and stall is low. The configuration channel uses
// valid/ready with cfg_index 0 for window_ms and 1 for max_entries; ready is
// always high and writes are expected only while the block is idle.
// A three-step microprogram runs each item: take, dispatch, then expire/push.
// Lock, clear, no-op and checks while locked finish in the dispatch step, so
// their result is registered from that step and the next item is taken
// once the sequencer is back in the take step. An unlocked check then stays
// in the expire step and pops expired stamps from the front of the timestamp
// RAM, one RAM read per cycle, before its result is registered and the next
// item can be taken; each stamp is popped once.
// Reset clears the counters and the lock and restores window_ms to 1000 and
// max_entries to 64; the stamp RAM needs no clearing pass, since only
// written entries are ever read. While the output register holds a result
// that the receiver stalls, no new input transaction is taken.
`default_nettype none

module sliding_window_flood_lock #(
  parameter int DEPTH = swfl_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [swfl_pkg::MODE_W-1:0]    mode,
  input  wire logic [swfl_pkg::TIME_W-1:0]    now_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                accepted,
  output logic                                locked,
  output logic [swfl_pkg::QUEUED_W-1:0]       queued,
  output logic [swfl_pkg::TIME_W-1:0]         total_accepted,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [swfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swfl_pkg::CFG_DAT_W-1:0] cfg_data
);

  import swfl_pkg::*;

  `include "sliding_window_flood_lock_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = OCC_W + LIMIT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  // Configuration registers.
  logic [TIME_W-1:0]  window_ms;
  logic [LIMIT_W-1:0] max_entries;

  // Limiter state.
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic              lock, lock_next;
  logic [TIME_W-1:0] last_add, last_add_next;
  logic [TIME_W-1:0] total, total_next;

  // Captured item.
  logic [MODE_W-1:0] mode_q;
  logic [TIME_W-1:0] now_q;

  // Sequencer interface.
  ctl_word_t  ctl;
  step_t      step;
  seq_flags_t flags;

  // Stamp RAM.
  logic              push;
  logic [TIME_W-1:0] rd_stamp;

  logic              out_load;
  logic              acc_next;
  logic [CMP_W-1:0]  occ_c;
  logic [CMP_W-1:0]  occ_next_c;
  logic              room;
  logic              take;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  swfl_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl),
    .step  (step)
  );

  // The read address follows the next head so that each pop cycle sees the
  // new front stamp in the following cycle.
  swfl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEPTH)
  ) u_stamps (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail),
    .wr_data (now_q),
    .rd_addr (head_next),
    .rd_data (rd_stamp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (ctl.op != OP_TAKE) || (out_valid && out_stall);
  assign take      = in_valid && !in_stall;

  // Effective limit is the smaller of max_entries and the RAM depth.
  assign occ_c = CMP_W'(occ);
  assign room  = (occ_c < CMP_W'(max_entries)) && (occ_c < CMP_W'(DEPTH));

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    occ_next      = occ;
    lock_next     = lock;
    last_add_next = last_add;
    total_next    = total;
    acc_next      = 1'b0;
    push          = 1'b0;
    out_load      = 1'b0;
    flags         = '{taken: take, done: 1'b0, pop: 1'b0};

    unique case (ctl.op)
      OP_TAKE: begin
      end
      OP_DISPATCH: begin
        flags.done = 1'b1;
        unique case (mode_q)
          MODE_CHECK: begin
            if (!lock) begin
              flags.done = 1'b0;
              // A stale newest stamp means every stamp has expired.
              if ((now_q - last_add) > window_ms) begin
                head_next = '0;
                tail_next = '0;
                occ_next  = '0;
              end
            end
          end
          MODE_LOCK: begin
            lock_next = 1'b1;
          end
          MODE_CLEAR: begin
            head_next     = '0;
            tail_next     = '0;
            occ_next      = '0;
            lock_next     = 1'b0;
            last_add_next = '0;
            total_next    = '0;
          end
          default: begin
          end
        endcase
        out_load = flags.done;
      end
      OP_EXPIRE: begin
        if ((occ != '0) && ((now_q - rd_stamp) > window_ms)) begin
          flags.pop = 1'b1;
          head_next = ptr_inc(head);
          occ_next  = occ - 1'b1;
        end else begin
          out_load = 1'b1;
          if (room) begin
            push          = 1'b1;
            tail_next     = ptr_inc(tail);
            occ_next      = occ + 1'b1;
            last_add_next = now_q;
            total_next    = total + 1'b1;
            acc_next      = 1'b1;
          end else begin
            lock_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign occ_next_c = CMP_W'(occ_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms   <= WINDOW_RESET;
      max_entries <= MAX_RESET;
      head        <= '0;
      tail        <= '0;
      occ         <= '0;
      lock        <= 1'b0;
      last_add    <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WINDOW: window_ms   <= cfg_data;
          REG_MAX:    max_entries <= cfg_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      head      <= head_next;
      tail      <= tail_next;
      occ       <= occ_next;
      lock      <= lock_next;
      last_add  <= last_add_next;
      total     <= total_next;
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      mode_q <= mode;
      now_q  <= now_ms;
    end
    if (out_load) begin
      accepted       <= acc_next;
      locked         <= lock_next;
      queued         <= occ_next_c[QUEUED_W-1:0];
      total_accepted <= total_next;
    end
  end

  `SWFL_ASSERT_SAME(a_occ_cap, 1'b1, occ <= OCC_W'(DEPTH),
    "stamp count exceeds RAM depth")
  `SWFL_ASSERT_SAME(a_take_idle, take, step == STEP_IDLE,
    "input transaction taken outside the idle step")
  `SWFL_ASSERT_SAME(a_acc_unlocked, out_valid && accepted, !locked,
    "admitted check reported with the lock set")
  `SWFL_ASSERT_NEXT(a_pop_count, flags.pop, occ == $past(occ) - 1'b1,
    "pop did not lower the stamp count by one")
  `SWFL_ASSERT_NEXT(a_load_empty, out_load, out_valid,
    "finished item did not present a result")

endmodule

`default_nettype wire
